FILE: src/loop_trip_count_profiler_top_assert.svh
// Assertion macros shared by the profiler RTL.
`ifndef LOOP_TRIP_COUNT_PROFILER_TOP_ASSERT_SVH
`define LOOP_TRIP_COUNT_PROFILER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("profiler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("profiler assertion failed");

`endif

FILE: src/ltcp_pkg.sv
package ltcp_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDRESS_BITS  = 48;
    localparam int COUNTER_BITS  = 32;
    localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);

    typedef logic [COUNTER_BITS-1:0] count_t;

    // One counter memory word per slot.
    typedef struct packed {
        count_t running;
        count_t total;
        count_t invocations;
        count_t changes;
        count_t prev_trip;
    } counters_t;

    typedef enum logic [1:0] {
        STAT_HIT  = 2'd0,
        STAT_NEW  = 2'd1,
        STAT_DROP = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    function automatic count_t sat_inc(input count_t value);
        count_t result;
        if (value == {COUNTER_BITS{1'b1}})
        begin
            result = value;
        end
        else
        begin
            result = value + count_t'(1);
        end
        return result;
    endfunction

endpackage

FILE: src/loop_trip_count_profiler_top.sv
// Channel   Direction  Transfer condition         Ports
// command   in         start && !busy             branch_address, taken
// result    out        done (one cycle, no stall) status, entry_index, total_iterations,
//                                                 loop_invocations, trip_changes,
//                                                 last_trip_count
//
// Each event passes through a lookup state (tag compare result encoded, counter
// memory read issued) and an update state (read-modify-write of the counter word).
// done and the result are registered from the update state; a new command is accepted there.
// In the table reset clears valid bits only; tags and counters are written on allocation.
// busy is high during the lookup cycle; the receiver cannot stall results.
`include "loop_trip_count_profiler_top_assert.svh"

module loop_trip_count_profiler_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ltcp_pkg::ADDRESS_BITS-1:0]    branch_address,
    input  logic                                 taken,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [ltcp_pkg::INDEX_BITS-1:0]      entry_index,
    output logic [ltcp_pkg::COUNTER_BITS-1:0]    total_iterations,
    output logic [ltcp_pkg::COUNTER_BITS-1:0]    loop_invocations,
    output logic [ltcp_pkg::COUNTER_BITS-1:0]    trip_changes,
    output logic [ltcp_pkg::COUNTER_BITS-1:0]    last_trip_count
);

    ltcp_pkg::state_t                          state_reg, state_next;
    logic [ltcp_pkg::TABLE_ENTRIES-1:0]        valid_reg;
    logic [ltcp_pkg::ADDRESS_BITS-1:0]         tag_mem [ltcp_pkg::TABLE_ENTRIES];
    ltcp_pkg::counters_t                       cnt_mem [ltcp_pkg::TABLE_ENTRIES];
    ltcp_pkg::counters_t                       rd_data_reg;

    logic [ltcp_pkg::ADDRESS_BITS-1:0]         addr_reg;
    logic                                      taken_reg;
    logic [ltcp_pkg::TABLE_ENTRIES-1:0]        hit_vec_reg, hit_vec_next;
    logic [ltcp_pkg::TABLE_ENTRIES-1:0]        free_vec_reg, free_vec_next;
    logic [ltcp_pkg::INDEX_BITS-1:0]           slot_reg, slot_next;
    ltcp_pkg::status_t                         status_reg, status_next;

    logic                                      done_reg;
    ltcp_pkg::status_t                         out_status_reg;
    logic [ltcp_pkg::INDEX_BITS-1:0]           out_index_reg;
    ltcp_pkg::counters_t                       out_cnt_reg;

    logic                                      accept;
    logic                                      lookup;
    logic                                      update;
    logic                                      wr_en;
    logic                                      alloc;
    logic                                      hit_any, free_any;
    logic [ltcp_pkg::INDEX_BITS-1:0]           hit_idx, free_idx;
    ltcp_pkg::counters_t                       upd_cnt;

    // State machine: next state
    always_comb
    begin
        unique case (state_reg)
            ltcp_pkg::ST_IDLE,
            ltcp_pkg::ST_UPDATE:
            begin
                state_next = (start) ? ltcp_pkg::ST_LOOKUP : ltcp_pkg::ST_IDLE;
            end
            ltcp_pkg::ST_LOOKUP:
            begin
                state_next = ltcp_pkg::ST_UPDATE;
            end
            default:
            begin
                state_next = ltcp_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine: outputs
    always_comb
    begin
        busy   = 1'b0;
        lookup = 1'b0;
        update = 1'b0;
        unique case (state_reg)
            ltcp_pkg::ST_IDLE:
            begin
            end
            ltcp_pkg::ST_LOOKUP:
            begin
                busy   = 1'b1;
                lookup = 1'b1;
            end
            ltcp_pkg::ST_UPDATE:
            begin
                update = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = start && !busy;
    assign wr_en  = update && (status_reg != ltcp_pkg::STAT_DROP);
    assign alloc  = update && (status_reg == ltcp_pkg::STAT_NEW);

    // Tag compare for the incoming event; forward a slot being allocated this cycle.
    always_comb
    begin
        logic alloc_here;
        logic valid_eff;
        logic tag_eq;
        for (int i = 0; i < ltcp_pkg::TABLE_ENTRIES; i++)
        begin
            alloc_here = alloc && (slot_reg == ltcp_pkg::INDEX_BITS'(i));
            valid_eff  = valid_reg[i] || alloc_here;
            tag_eq     = alloc_here ? (branch_address == addr_reg)
                                    : (tag_mem[i] == branch_address);
            hit_vec_next[i]  = valid_eff && tag_eq;
            free_vec_next[i] = !valid_eff;
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ltcp_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = ltcp_pkg::INDEX_BITS'(i);
            end
            if (free_vec_reg[i])
            begin
                free_idx = ltcp_pkg::INDEX_BITS'(i);
            end
        end
        hit_any  = |hit_vec_reg;
        free_any = |free_vec_reg;
    end

    always_comb
    begin
        if (hit_any)
        begin
            slot_next   = hit_idx;
            status_next = ltcp_pkg::STAT_HIT;
        end
        else if (free_any)
        begin
            slot_next   = free_idx;
            status_next = ltcp_pkg::STAT_NEW;
        end
        else
        begin
            slot_next   = '0;
            status_next = ltcp_pkg::STAT_DROP;
        end
    end

    // Counter update on the word read during lookup; a new slot starts cleared.
    always_comb
    begin
        ltcp_pkg::counters_t cur;
        ltcp_pkg::count_t    run_inc;
        cur = (status_reg == ltcp_pkg::STAT_NEW) ? '0 : rd_data_reg;
        run_inc = ltcp_pkg::sat_inc(cur.running);
        upd_cnt = cur;
        upd_cnt.running = run_inc;
        upd_cnt.total   = ltcp_pkg::sat_inc(cur.total);
        if (!taken_reg)
        begin
            upd_cnt.invocations = ltcp_pkg::sat_inc(cur.invocations);
            if ((cur.prev_trip != '0) && (cur.prev_trip != run_inc))
            begin
                upd_cnt.changes = ltcp_pkg::sat_inc(cur.changes);
            end
            upd_cnt.prev_trip = run_inc;
            upd_cnt.running   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltcp_pkg::ST_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= update;
            if (alloc)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // Event and lookup payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg     <= branch_address;
            taken_reg    <= taken;
            hit_vec_reg  <= hit_vec_next;
            free_vec_reg <= free_vec_next;
        end
        if (lookup)
        begin
            slot_reg   <= slot_next;
            status_reg <= status_next;
        end
        if (update)
        begin
            out_status_reg <= status_reg;
            if (status_reg == ltcp_pkg::STAT_DROP)
            begin
                out_index_reg <= '0;
                out_cnt_reg   <= '0;
            end
            else
            begin
                out_index_reg <= slot_reg;
                out_cnt_reg   <= upd_cnt;
            end
        end
    end

    // Tag store
    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            tag_mem[slot_reg] <= addr_reg;
        end
    end

    // Counter memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            rd_data_reg <= cnt_mem[slot_next];
        end
        if (wr_en)
        begin
            cnt_mem[slot_reg] <= upd_cnt;
        end
    end

    assign done             = done_reg;
    assign status           = out_status_reg;
    assign entry_index      = out_index_reg;
    assign total_iterations = out_cnt_reg.total;
    assign loop_invocations = out_cnt_reg.invocations;
    assign trip_changes     = out_cnt_reg.changes;
    assign last_trip_count  = out_cnt_reg.prev_trip;

    `LTCP_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `LTCP_ASSERT_NEXT(a_update_done, clk, rst_n, update, done)
    `LTCP_ASSERT_NEXT(a_valid_sticky, clk, rst_n, 1'b1, ($past(valid_reg) & ~valid_reg) == '0)
    `LTCP_ASSERT_NOW(a_drop_zero, clk, rst_n,
        done && (status == ltcp_pkg::STAT_DROP), (entry_index == '0) && (last_trip_count == '0))

endmodule

FILE: bench/loop_trip_count_profiler_top_tb.sv
`timescale 1ns / 1ps

module loop_trip_count_profiler_top_tb;

    import ltcp_pkg::*;

    typedef logic [ADDRESS_BITS-1:0] addr_t;

    typedef struct {
        addr_t addr;
        logic  taken;
    } branch_event_t;

    typedef struct {
        status_t               status;
        logic [INDEX_BITS-1:0] slot;
        count_t                total;
        count_t                invocations;
        count_t                changes;
        count_t                last_trip;
    } profile_result_t;

    localparam int POOL_SIZE = 80;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    addr_t                   branch_address = '0;
    logic                    taken = 1'b0;
    logic                    done;
    logic [1:0]              status;
    logic [INDEX_BITS-1:0]   entry_index;
    count_t                  total_iterations;
    count_t                  loop_invocations;
    count_t                  trip_changes;
    count_t                  last_trip_count;

    // Shadow copy of the profiling table
    logic                    tag_valid [TABLE_ENTRIES];
    addr_t                   tag_addr  [TABLE_ENTRIES];
    count_t                  run_cnt   [TABLE_ENTRIES];
    count_t                  total_cnt [TABLE_ENTRIES];
    count_t                  inv_cnt   [TABLE_ENTRIES];
    count_t                  chg_cnt   [TABLE_ENTRIES];
    count_t                  trip_cnt  [TABLE_ENTRIES];

    branch_event_t           branch_queue[$];
    profile_result_t         expected_counts[$];
    addr_t                   loop_pool [POOL_SIZE];

    logic                    cmd_xfer = 1'b0;
    int                      idle_pct = 0;
    int                      queued = 0;
    int                      accepted = 0;
    int                      error_count = 0;
    int                      hit_seen = 0;
    int                      alloc_seen = 0;
    int                      drop_seen = 0;
    int                      exit_seen = 0;

    loop_trip_count_profiler_top i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .branch_address   (branch_address),
        .taken            (taken),
        .done             (done),
        .status           (status),
        .entry_index      (entry_index),
        .total_iterations (total_iterations),
        .loop_invocations (loop_invocations),
        .trip_changes     (trip_changes),
        .last_trip_count  (last_trip_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #1ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic count_t bump(input count_t value);
        count_t result;
        result = (value == '1) ? value : value + count_t'(1);
        return result;
    endfunction

    // Look up or allocate the slot for one branch event and update its counters.
    function automatic profile_result_t profile_branch(input addr_t addr, input logic is_taken);
        profile_result_t r;
        int              hit_slot;
        int              free_slot;
        int              s;
        int              i;
        hit_slot  = -1;
        free_slot = -1;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tag_valid[i])
            begin
                if (hit_slot < 0 && tag_addr[i] == addr)
                begin
                    hit_slot = i;
                end
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        r.status      = STAT_DROP;
        r.slot        = '0;
        r.total       = '0;
        r.invocations = '0;
        r.changes     = '0;
        r.last_trip   = '0;
        if (hit_slot >= 0)
        begin
            s        = hit_slot;
            r.status = STAT_HIT;
        end
        else if (free_slot >= 0)
        begin
            s            = free_slot;
            r.status     = STAT_NEW;
            tag_valid[s] = 1'b1;
            tag_addr[s]  = addr;
            run_cnt[s]   = '0;
            total_cnt[s] = '0;
            inv_cnt[s]   = '0;
            chg_cnt[s]   = '0;
            trip_cnt[s]  = '0;
        end
        else
        begin
            return r;
        end
        run_cnt[s]   = bump(run_cnt[s]);
        total_cnt[s] = bump(total_cnt[s]);
        if (!is_taken)
        begin
            inv_cnt[s] = bump(inv_cnt[s]);
            if (trip_cnt[s] != '0 && trip_cnt[s] != run_cnt[s])
            begin
                chg_cnt[s] = bump(chg_cnt[s]);
            end
            trip_cnt[s] = run_cnt[s];
            run_cnt[s]  = '0;
        end
        r.slot        = INDEX_BITS'(s);
        r.total       = total_cnt[s];
        r.invocations = inv_cnt[s];
        r.changes     = chg_cnt[s];
        r.last_trip   = trip_cnt[s];
        return r;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic queue_branch(input addr_t addr, input logic is_taken);
        branch_event_t item;
        item.addr  = addr;
        item.taken = is_taken;
        branch_queue.push_back(item);
        queued++;
    endtask

    // One loop run: some taken iterations, then the exit.
    task automatic queue_loop_run(input int pool_lim);
        addr_t addr;
        int    trips;
        addr  = loop_pool[$urandom_range(pool_lim - 1)];
        trips = $urandom_range(3);
        if ($urandom_range(3) == 0)
        begin
            trips = $urandom_range(20);
        end
        repeat (trips) queue_branch(addr, 1'b1);
        queue_branch(addr, 1'b0);
    endtask

    task automatic queue_phase(input int pool_lim, input int n_items);
        int target;
        target = queued + n_items;
        while (queued < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                queue_loop_run(pool_lim);
            end
            else if ($urandom_range(1) == 1)
            begin
                queue_branch(ADDRESS_BITS'({$urandom, $urandom}), 1'($urandom));
            end
            else
            begin
                queue_branch(loop_pool[$urandom_range(pool_lim - 1)], 1'($urandom));
            end
        end
    endtask

    // Hold until every queued event is transferred and every result has come back.
    task automatic drain;
        while (branch_queue.size() > 0 || start)
        begin
            @(posedge clk);
        end
        while (expected_counts.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(negedge clk)
    begin : drive
        branch_event_t item;
        if (rst_n && (!start || cmd_xfer))
        begin
            if (branch_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                item = branch_queue.pop_front();
                branch_address <= item.addr;
                taken          <= item.taken;
                start          <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        profile_result_t want;
        if (rst_n)
        begin
            cmd_xfer <= start && !busy;
            if (done === 1'b1)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d slot %0d",
                             $time, status, entry_index);
                    error_count++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    report_field("status", 32'(want.status), 32'(status));
                    report_field("entry_index", 32'(want.slot), 32'(entry_index));
                    report_field("total_iterations", want.total, total_iterations);
                    report_field("loop_invocations", want.invocations, loop_invocations);
                    report_field("trip_changes", want.changes, trip_changes);
                    report_field("last_trip_count", want.last_trip, last_trip_count);
                    case (want.status)
                        STAT_HIT: hit_seen++;
                        STAT_NEW: alloc_seen++;
                        default:  drop_seen++;
                    endcase
                end
            end
            if (start && !busy)
            begin
                expected_counts.push_back(profile_branch(branch_address, taken));
                accepted++;
                if (!taken)
                begin
                    exit_seen++;
                end
            end
        end
        else
        begin
            cmd_xfer <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            tag_valid[i] = 1'b0;
        end
        for (i = 0; i < POOL_SIZE; i++)
        begin
            loop_pool[i] = ADDRESS_BITS'({$urandom, $urandom});
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: allocation, first exit against a zero trip, a changed trip,
        // a repeated trip, address extremes and near-miss tags.
        idle_pct = 14;
        queue_branch('0, 1'b1);
        queue_branch('0, 1'b0);
        queue_branch('0, 1'b0);
        queue_branch('0, 1'b0);
        queue_branch('1, 1'b0);
        queue_branch('1, 1'b1);
        queue_branch('1, 1'b1);
        queue_branch('1, 1'b0);
        queue_branch('1, 1'b1);
        queue_branch('1, 1'b1);
        queue_branch('1, 1'b0);
        queue_branch({(ADDRESS_BITS/2){2'b10}}, 1'b1);
        queue_branch({(ADDRESS_BITS/2){2'b01}}, 1'b0);
        queue_branch({1'b1, {(ADDRESS_BITS-1){1'b0}}}, 1'b0);
        queue_branch(addr_t'(1), 1'b1);
        queue_branch(addr_t'(1), 1'b0);
        queue_branch('0, 1'b1);
        queue_branch({1'b0, {(ADDRESS_BITS-1){1'b1}}}, 1'b0);
        queue_phase(16, 170);
        drain();

        // Larger working set, sparse sender; the table fills up here.
        idle_pct = 64;
        queue_phase(40, 180);
        drain();

        // More branches than slots, back-to-back: drops mix with hits.
        idle_pct = 0;
        queue_phase(POOL_SIZE, 180);
        drain();

        repeat (10) @(posedge clk);
        if (expected_counts.size() > 0)
        begin
            $display("%0t: missing results: expected %0d more, actual 0",
                     $time, expected_counts.size());
            error_count++;
        end

        $display("Ran %0d branch events (%0d loop exits): %0d hits, %0d allocations, %0d drops.",
                 accepted, exit_seen, hit_seen, alloc_seen, drop_seen);
        $display("Sender idle at 14%%, 64%% and 0%% with a full drain between phases.");
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
